FILE: design/mfu_pkg.sv
// Shared constants for the MFU page replacement block: field widths,
// stream beat widths and sequencer state codes. No dependencies.
`default_nettype none

package mfu_pkg;

  // field widths of one beat
  localparam int PAGE_W      = 8;
  localparam int FRAME_IDX_W = 3;
  localparam int USE_COUNT_W = 16;

  // stream beat widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (2 + PAGE_W + FRAME_IDX_W + USE_COUNT_W);

  // sequencer states
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
  localparam logic [ST_W-1:0] ST_FIND  = 3'd2;
  localparam logic [ST_W-1:0] ST_SCAN  = 3'd3;
  localparam logic [ST_W-1:0] ST_EVICT = 3'd4;
  localparam logic [ST_W-1:0] ST_CREAD = 3'd5;
  localparam logic [ST_W-1:0] ST_CUPD  = 3'd6;

endpackage

`default_nettype wire

FILE: design/mfu_count_ram.sv
// Use-count store: single write port, single read port, registered read.
// No dependencies.
`default_nettype none

module mfu_count_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/mfu_page_replacement.sv
// Flow: a hit or a fill of an empty frame passes ST_FIND, ST_CREAD and ST_CUPD, and the
//   result beat is registered in ST_CUPD; an eviction adds a count scan and ST_EVICT.
// Pages: a new page is taken only in ST_IDLE, once the last result beat is registered;
//   the count scan and the update share the single read port of the count RAM.
// Reset: synchronous rst empties all frames, then a clearing pass writes zero to every
//   count entry, with s_axis_tready low until it finishes.
// Depends on mfu_pkg and mfu_count_ram.
`default_nettype none

module mfu_page_replacement #(
  parameter int NUM_FRAMES = 8,
  parameter int NUM_PAGES  = 256,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [mfu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] page_number
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] hit, [1] evicted, [9:2] victim_page, [12:10] frame_index,
  // [28:13] use_count, [31:29] zero
  output logic      [mfu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int FRAME_AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int SCAN_W   = $clog2(NUM_FRAMES + 1);
  localparam int PAGE_AW  = $clog2(NUM_PAGES);

  localparam int PW = mfu_pkg::PAGE_W;

  // count-store index: pages past the store share the top entry
  function automatic logic [PAGE_AW-1:0] page_slot(input logic [PW-1:0] p);
    logic [12:0] wide;
    wide = 13'(p);
    if (wide < 13'(NUM_PAGES)) begin
      page_slot = wide[PAGE_AW-1:0];
    end else begin
      page_slot = PAGE_AW'(NUM_PAGES - 1);
    end
  endfunction

  // control state
  logic [mfu_pkg::ST_W-1:0] state;
  logic [PAGE_AW-1:0]       clr_addr;
  logic [SCAN_W-1:0]        scan_cnt;
  logic [NUM_FRAMES-1:0]    frame_valid;

  // payload
  logic [PW-1:0]            frame_page [NUM_FRAMES];
  logic [PW-1:0]            pg_q;
  logic                     hit_q;
  logic                     ev_q;
  logic [PW-1:0]            victim_q;
  logic [FRAME_AW-1:0]      slot_q;
  logic [COUNT_BITS-1:0]    best_cnt;
  logic [FRAME_AW-1:0]      best_idx;
  logic [PW-1:0]            scan_page_q;

  // count RAM port
  logic                     ram_we;
  logic [PAGE_AW-1:0]       ram_waddr;
  logic [COUNT_BITS-1:0]    ram_wdata;
  logic [PAGE_AW-1:0]       ram_raddr;
  logic [COUNT_BITS-1:0]    ram_rdata;

  mfu_count_ram #(
    .DEPTH (NUM_PAGES),
    .AW    (PAGE_AW),
    .DW    (COUNT_BITS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // frame lookup, parallel over frames: first matching frame, first empty frame
  logic                hit_found;
  logic [FRAME_AW-1:0] hit_idx;
  logic                empty_found;
  logic [FRAME_AW-1:0] empty_idx;

  always_comb begin
    hit_found   = 1'b0;
    hit_idx     = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (frame_valid[i] && (frame_page[i] == pg_q)) begin
        hit_found = 1'b1;
        hit_idx   = FRAME_AW'(i);
      end
      if (!frame_valid[i]) begin
        empty_found = 1'b1;
        empty_idx   = FRAME_AW'(i);
      end
    end
  end

  // saturating increment of the count read back in ST_CUPD
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           cnt_ext;
  logic [6:0]            slot_ext;
  logic                  out_go;
  logic                  scan_issue;

  assign cnt_inc  = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
  assign cnt_ext  = 32'(cnt_inc);
  assign slot_ext = 7'(slot_q);
  // result register free, or being emptied this cycle
  assign out_go   = !m_axis_tvalid || m_axis_tready;
  assign scan_issue = (state == mfu_pkg::ST_SCAN) && (scan_cnt < SCAN_W'(NUM_FRAMES));

  assign s_axis_tready = (state == mfu_pkg::ST_IDLE);

  // RAM addressing: scan reads resident pages, otherwise the referenced page.
  // The write in ST_CUPD lands before the next item's first read, with ST_IDLE and
  // ST_FIND between them, so no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = page_slot(pg_q);
    ram_wdata = cnt_inc;
    ram_raddr = page_slot(pg_q);
    if (state == mfu_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == mfu_pkg::ST_CUPD) begin
      ram_we    = out_go;
    end
    if (scan_issue) begin
      ram_raddr = page_slot(frame_page[scan_cnt[FRAME_AW-1:0]]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mfu_pkg::ST_CLEAR;
      clr_addr    <= '0;
      scan_cnt    <= '0;
      frame_valid <= '0;
    end else begin
      unique case (state)
        mfu_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PAGE_AW'(NUM_PAGES - 1)) begin
            state <= mfu_pkg::ST_IDLE;
          end
        end
        mfu_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= mfu_pkg::ST_FIND;
          end
        end
        mfu_pkg::ST_FIND: begin
          scan_cnt <= '0;
          if (hit_found || empty_found) begin
            state <= mfu_pkg::ST_CREAD;
          end else begin
            state <= mfu_pkg::ST_SCAN;
          end
        end
        mfu_pkg::ST_SCAN: begin
          if (scan_cnt == SCAN_W'(NUM_FRAMES)) begin
            state <= mfu_pkg::ST_EVICT;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        mfu_pkg::ST_EVICT: begin
          state <= mfu_pkg::ST_CREAD;
        end
        mfu_pkg::ST_CREAD: begin
          if (!hit_q) begin
            frame_valid[slot_q] <= 1'b1;
          end
          state <= mfu_pkg::ST_CUPD;
        end
        mfu_pkg::ST_CUPD: begin
          if (out_go) begin
            state <= mfu_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= mfu_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == mfu_pkg::ST_IDLE) begin
      pg_q <= s_axis_tdata[PW-1:0];
    end
    if (state == mfu_pkg::ST_FIND) begin
      hit_q    <= hit_found;
      ev_q     <= 1'b0;
      victim_q <= '0;
      slot_q   <= hit_found ? hit_idx : empty_idx;
    end
    if (scan_issue) begin
      scan_page_q <= frame_page[scan_cnt[FRAME_AW-1:0]];
    end
    // count of frame scan_cnt-1 is on the RAM output; strict > keeps the lowest index
    if ((state == mfu_pkg::ST_SCAN) && (scan_cnt != '0)) begin
      if ((scan_cnt == SCAN_W'(1)) || (ram_rdata > best_cnt)) begin
        best_cnt <= ram_rdata;
        best_idx <= FRAME_AW'(scan_cnt - 1'b1);
        victim_q <= scan_page_q;
      end
    end
    if (state == mfu_pkg::ST_EVICT) begin
      slot_q <= best_idx;
      ev_q   <= 1'b1;
    end
    if ((state == mfu_pkg::ST_CREAD) && !hit_q) begin
      frame_page[slot_q] <= pg_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == mfu_pkg::ST_CUPD) && out_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == mfu_pkg::ST_CUPD) && out_go) begin
      m_axis_tdata <= {{mfu_pkg::OUT_PAD_W{1'b0}},
                       cnt_ext[mfu_pkg::USE_COUNT_W-1:0],
                       slot_ext[mfu_pkg::FRAME_IDX_W-1:0],
                       victim_q, ev_q, hit_q};
    end
  end

  // checks
  a_hit_not_evict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("result beat flags both hit and eviction");

  a_hit_frame_holds_page: assert property (@(posedge clk) disable iff (rst)
    ((state == mfu_pkg::ST_CUPD) && hit_q) |-> (frame_valid[slot_q] &&
                                                (frame_page[slot_q] == pg_q)))
    else $error("hit frame does not hold the referenced page");

  a_evict_only_full: assert property (@(posedge clk) disable iff (rst)
    (state == mfu_pkg::ST_EVICT) |-> (&frame_valid))
    else $error("eviction with an empty frame present");

  a_accept_to_find: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == mfu_pkg::ST_FIND))
    else $error("accepted page did not start a lookup");

endmodule

`default_nettype wire
